/* src/ucld_pkg.sv */
// Shared types, constants and command word tables for the command line decoder.
// No dependencies; the line tracker, the resolver and the top level import this package.
`default_nettype none

package ucld_pkg;

  // Line store sizing: LINE_CAPACITY-1 bytes of text fit in one line.
  localparam int unsigned LINE_CAPACITY = 32;
  localparam int unsigned STORE_DEPTH   = LINE_CAPACITY - 1;
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // Position of the receiver select argument byte.
  localparam int unsigned RX_ARG_POS = 10;

  // Command words, matched against the text of a closed line.
  localparam int unsigned NUM_WORDS = 7;
  localparam int unsigned MAX_WORD  = 15;
  localparam int unsigned WORD_BITS = 8 * MAX_WORD;

  localparam int unsigned W_LFM    = 0;
  localparam int unsigned W_BARKER = 1;
  localparam int unsigned W_SINGLE = 2;
  localparam int unsigned W_RXSEL  = 3;
  localparam int unsigned W_RAW    = 4;
  localparam int unsigned W_BPF    = 5;
  localparam int unsigned W_COMP   = 6;

  // Literals are right-justified: the first character sits in the top used byte.
  localparam logic [WORD_BITS-1:0] WORD_LIT [NUM_WORDS] = '{
    WORD_BITS'("cfg:lfm"),
    WORD_BITS'("cfg:barker13"),
    WORD_BITS'("cfg:single"),
    WORD_BITS'({"rx_", "select:"}),
    WORD_BITS'("mode:raw"),
    WORD_BITS'("mode:bpf"),
    WORD_BITS'("mode:compressed")
  };

  localparam logic [LEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
    LEN_W'(7), LEN_W'(12), LEN_W'(10), LEN_W'(10), LEN_W'(8), LEN_W'(8), LEN_W'(15)
  };

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LFM    = 3'd1,
    CMD_SINGLE = 3'd2,
    CMD_RXSEL  = 3'd3,
    CMD_RAW    = 3'd4,
    CMD_BPF    = 3'd5,
    CMD_COMP   = 3'd6
  } cmd_e;

  localparam logic [1:0] STREAM_RAW  = 2'd0;
  localparam logic [1:0] STREAM_BPF  = 2'd1;
  localparam logic [1:0] STREAM_COMP = 2'd2;

  localparam logic       PULSE_LFM    = 1'b0;
  localparam logic       PULSE_SINGLE = 1'b1;

  localparam logic [7:0] RX_SEL_RESET = 8'd1;

  // Running state of the line being collected.
  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic                 zero_seen;
    logic [LEN_W-1:0]     zero_pos;
    logic [NUM_WORDS-1:0] word_ok;
    logic [7:0]           arg;
  } line_status_t;

  // Outcome of one byte.
  typedef struct packed {
    logic       done;
    cmd_e       code;
    logic       drop;
    logic [7:0] rx_value;
  } decode_t;

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

  // Character of a command word at a position; zero past the end of the word.
  function automatic logic [7:0] word_byte(input int unsigned idx,
                                           input logic [LEN_W-1:0] pos);
    logic [WORD_BITS-1:0] lit;
    int unsigned          n;
    int unsigned          p;
    lit = WORD_LIT[idx];
    n   = int'(WORD_LEN[idx]);
    p   = int'(pos);
    if (p < n) begin
      return lit[8*(n-1-p) +: 8];
    end
    return CHAR_NUL;
  endfunction

endpackage

`default_nettype wire

/* src/ucld_if.sv */
// Handshake channels of the command line decoder: received bytes in, results out.
// No dependencies; field widths follow the result word of the decoder.
`default_nettype none

interface ucld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucld_res_if;
  logic       valid;
  logic       ready;
  logic       line_done;
  logic [2:0] command_code;
  logic       pulse_write;
  logic       pulse_kind;
  logic [7:0] receiver_select;
  logic [1:0] stream_kind;
  logic       overflow_drop;

  modport source (output valid, output line_done, output command_code,
                  output pulse_write, output pulse_kind, output receiver_select,
                  output stream_kind, output overflow_drop, input ready);
  modport sink   (input valid, input line_done, input command_code,
                  input pulse_write, input pulse_kind, input receiver_select,
                  input stream_kind, input overflow_drop, output ready);
endinterface

`default_nettype wire

/* src/ucld_line_tracker.sv */
// Incremental line matcher: length, first zero byte, per-word match flags, argument.
// Depends on ucld_pkg.
`default_nettype none

module ucld_line_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [7:0]            byte_i,
  output ucld_pkg::line_status_t status_o
);
  import ucld_pkg::*;

  line_status_t st_q, st_d;
  logic         restart;

  assign restart = is_terminator(byte_i) || (st_q.len == LEN_W'(STORE_DEPTH));

  always_comb begin
    st_d = st_q;
    if (restart) begin
      st_d.len       = '0;
      st_d.zero_seen = 1'b0;
      st_d.word_ok   = '1;
    end else begin
      if (!st_q.zero_seen) begin
        if (byte_i == CHAR_NUL) begin
          st_d.zero_seen = 1'b1;
          st_d.zero_pos  = st_q.len;
        end else begin
          // Clear a word's flag on the first mismatch inside its length.
          for (int unsigned i = 0; i < NUM_WORDS; i++) begin
            if ((st_q.len < WORD_LEN[i]) && (byte_i != word_byte(i, st_q.len))) begin
              st_d.word_ok[i] = 1'b0;
            end
          end
        end
      end
      if (st_q.len == LEN_W'(RX_ARG_POS)) begin
        st_d.arg = byte_i;
      end
      st_d.len = st_q.len + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.len       <= '0;
      st_q.zero_seen <= 1'b0;
      st_q.zero_pos  <= '0;
      st_q.word_ok   <= '1;
      st_q.arg       <= CHAR_NUL;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

  assign status_o = st_q;

endmodule

`default_nettype wire

/* src/ucld_cmd_resolve.sv */
// Resolves one byte against the tracked line: done, drop, command code, argument.
// Depends on ucld_pkg.
`default_nettype none

module ucld_cmd_resolve (
  input  logic [7:0]             byte_i,
  input  ucld_pkg::line_status_t status_i,
  output ucld_pkg::decode_t      decode_o
);
  import ucld_pkg::*;

  logic [LEN_W-1:0]     eff;
  logic [NUM_WORDS-1:0] hit;
  logic                 rx_hit;
  logic [7:0]           arg;
  logic                 term;

  assign term = is_terminator(byte_i);
  assign eff  = status_i.zero_seen ? status_i.zero_pos : status_i.len;

  always_comb begin
    for (int unsigned i = 0; i < NUM_WORDS; i++) begin
      hit[i] = status_i.word_ok[i] && (eff == WORD_LEN[i]);
    end
  end

  assign rx_hit = status_i.word_ok[W_RXSEL] && (eff >= LEN_W'(RX_ARG_POS));
  assign arg    = (status_i.len > LEN_W'(RX_ARG_POS)) ? status_i.arg : CHAR_NUL;

  always_comb begin
    decode_o.done     = term && (status_i.len != '0);
    decode_o.drop     = !term && (status_i.len == LEN_W'(STORE_DEPTH));
    decode_o.rx_value = arg - CHAR_ZERO;
    decode_o.code     = CMD_NONE;
    if (decode_o.done) begin
      priority if (hit[W_LFM] || hit[W_BARKER]) decode_o.code = CMD_LFM;
      else if (hit[W_SINGLE])                   decode_o.code = CMD_SINGLE;
      else if (rx_hit)                          decode_o.code = CMD_RXSEL;
      else if (hit[W_RAW])                      decode_o.code = CMD_RAW;
      else if (hit[W_BPF])                      decode_o.code = CMD_BPF;
      else if (hit[W_COMP])                     decode_o.code = CMD_COMP;
      else                                      decode_o.code = CMD_NONE;
    end
  end

endmodule

`default_nettype wire

/* src/uart_command_line_decoder.sv */
// Top level of the serial command line decoder: input register, matcher, result register.
// Depends on ucld_pkg, ucld_if, ucld_line_tracker and ucld_cmd_resolve.
`default_nettype none

// Each received byte on rx_i yields exactly one result word on res_o, in order.
// The block takes one byte per cycle unless the input stalls. An accepted byte is held in
// the input register; its result word is then loaded into the result register and offered
// on res_o until res_o.ready takes it. The input stalls only when both registers are full
// and res_o.ready is low; rx_i.ready then follows res_o.ready in the same cycle.
// Lines are matched as they arrive: per-word match flags replace a stored copy of the
// text, so a CR or LF resolves its command in the same cycle. Receiver selection
// resets to 1 and stream mode to raw.
module uart_command_line_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  ucld_rx_if.sink           rx_i,
  ucld_res_if.source        res_o
);
  import ucld_pkg::*;

  // Input stage: hold one byte until the result register can take it.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // Result stage.
  logic       out_valid_q;
  logic       out_free;
  logic       s1_ready;
  logic       advance;

  line_status_t status;
  decode_t      dec;

  // Settings that survive between lines.
  logic [7:0] rx_sel_q, rx_sel_d;
  logic [1:0] mode_q, mode_d;

  logic       res_done_q;
  cmd_e       res_code_q;
  logic       res_drop_q;

  assign out_free = !out_valid_q || res_o.ready;
  assign s1_ready = !s1_valid_q || out_free;
  assign advance  = s1_valid_q && out_free;
  assign rx_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && rx_i.valid) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  ucld_line_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (s1_byte_q),
    .status_o  (status)
  );

  ucld_cmd_resolve u_resolve (
    .byte_i   (s1_byte_q),
    .status_i (status),
    .decode_o (dec)
  );

  // Apply the command to the persistent settings.
  always_comb begin
    rx_sel_d = rx_sel_q;
    mode_d   = mode_q;
    unique case (dec.code)
      CMD_RXSEL: rx_sel_d = dec.rx_value;
      CMD_RAW:   mode_d   = STREAM_RAW;
      CMD_BPF:   mode_d   = STREAM_BPF;
      CMD_COMP:  mode_d   = STREAM_COMP;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rx_sel_q    <= RX_SEL_RESET;
      mode_q      <= STREAM_RAW;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance) begin
        rx_sel_q <= rx_sel_d;
        mode_q   <= mode_d;
      end
    end
  end

  // Result payload; settings fields read the updated rx_sel_q/mode_q directly.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_done_q <= dec.done;
      res_code_q <= dec.code;
      res_drop_q <= dec.drop;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.line_done       = res_done_q;
  assign res_o.command_code    = res_code_q;
  assign res_o.pulse_write     = (res_code_q == CMD_LFM) || (res_code_q == CMD_SINGLE);
  assign res_o.pulse_kind      = (res_code_q == CMD_SINGLE) ? PULSE_SINGLE : PULSE_LFM;
  assign res_o.receiver_select = rx_sel_q;
  assign res_o.stream_kind     = mode_q;
  assign res_o.overflow_drop   = res_drop_q;

  // A dropped byte or a closed line restarts the line.
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (dec.drop || dec.done) |=> status.len == '0)
    else $error("line length not cleared after restart");

  // A stored byte grows the line by one.
  a_len_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !is_terminator(s1_byte_q) && !dec.drop
    |=> status.len == $past(status.len) + LEN_W'(1))
    else $error("line length did not advance");

  // A command is only reported for a closed line.
  a_code_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_done_q |-> res_code_q == CMD_NONE)
    else $error("command reported without a closed line");

  // Stream mode stays within its three settings.
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("stream mode out of range");

  // The settings move only when a byte is processed.
  a_settings_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(rx_sel_q) && $stable(mode_q))
    else $error("settings changed without a byte");

endmodule

`default_nettype wire
